@@ sv/tli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape language interpreter package
// Symbol and operation codes, default sizes and the character decoder.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TAPE_CELLS_DEF  = 4096;
    localparam int PROG_LEN_DEF    = 1024;
    localparam int NEST_DEPTH_DEF  = 64;
    localparam int INPUT_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        OP_LOAD_PROG  = 2'd0,
        OP_LOAD_INPUT = 2'd1,
        OP_STEP       = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        SYM_LEFT  = 3'd0,
        SYM_RIGHT = 3'd1,
        SYM_INC   = 3'd2,
        SYM_DEC   = 3'd3,
        SYM_OUT   = 3'd4,
        SYM_IN    = 3'd5,
        SYM_OPEN  = 3'd6,
        SYM_CLOSE = 3'd7
    } t_sym;

    typedef struct packed {
        logic ok;
        t_sym sym;
    } t_dec;

    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    function automatic t_dec decode_char(input logic [7:0] ch);
        t_dec d;
        d.ok  = 1'b1;
        d.sym = SYM_LEFT;
        case (ch)
            CH_LEFT:  d.sym = SYM_LEFT;
            CH_RIGHT: d.sym = SYM_RIGHT;
            CH_INC:   d.sym = SYM_INC;
            CH_DEC:   d.sym = SYM_DEC;
            CH_OUT:   d.sym = SYM_OUT;
            CH_IN:    d.sym = SYM_IN;
            CH_OPEN:  d.sym = SYM_OPEN;
            CH_CLOSE: d.sym = SYM_CLOSE;
            default:  d.ok  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ sv/tli_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape language interpreter RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tape_language_interpreter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape language interpreter
// Loads program symbols and input bytes, executes one instruction per step.
// ----------------------------------------------------------------------------
// After reset the tape is swept to zero, one cell a cycle, so the block takes
// no word until the whole tape is cleared. Program and input loads finish in
// the cycle they are taken, except a closing bracket, which pops the stack and
// then patches the jump table in states S_POP1 and S_POP2 through its single
// write port. In a step the program, jump table, tape and input memories are
// read when the step is taken and the tape is written back in state S_EXEC; a
// step that finds the machine halted or in error finishes in the cycle it is
// taken. One word is worked on at a time; the next one is taken only when the
// output register is empty or its result is being taken in that same cycle.
module tape_language_interpreter #(
    parameter int TAPE_CELLS  = tli_pkg::TAPE_CELLS_DEF,
    parameter int PROG_LEN    = tli_pkg::PROG_LEN_DEF,
    parameter int NEST_DEPTH  = tli_pkg::NEST_DEPTH_DEF,
    parameter int INPUT_DEPTH = tli_pkg::INPUT_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_halted,
    output logic       o_error
);

    localparam int PAW = $clog2(PROG_LEN);
    localparam int PCW = $clog2(PROG_LEN + 1);
    localparam int TAW = $clog2(TAPE_CELLS);
    localparam int SAW = $clog2(NEST_DEPTH);
    localparam int SDW = $clog2(NEST_DEPTH + 1);
    localparam int FAW = $clog2(INPUT_DEPTH);
    localparam int FCW = $clog2(INPUT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POP1,
        S_POP2,
        S_EXEC
    } t_state;

    t_state           r_state, n_state;
    logic [PCW-1:0]   r_len, n_len, r_pc, n_pc;
    logic [SDW-1:0]   r_depth, n_depth;
    logic [TAW-1:0]   r_ptr, n_ptr, r_clr, n_clr;
    logic [FAW-1:0]   r_head, n_head, r_tail, n_tail;
    logic [FCW-1:0]   r_cnt, n_cnt;
    logic             r_err, n_err;
    logic [PAW-1:0]   r_at, n_at;
    logic             r_ov, n_ov;
    logic             r_obv, n_obv;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_ohalt, n_ohalt;
    logic             r_oerr, n_oerr;

    logic             w_emit, w_free, w_acc;
    logic             w_obv;
    logic [7:0]       w_obyte;
    logic [SDW-1:0]   w_dm1;
    tli_pkg::t_dec    w_dec;
    tli_pkg::t_sym    w_sym;

    // memory ports
    logic             prog_we, prog_re;
    logic [2:0]       prog_q;
    logic             jt_we, jt_re;
    logic [PAW-1:0]   jt_waddr, jt_wdata, jt_q;
    logic             stk_we, stk_re;
    logic [PAW-1:0]   stk_q;
    logic             tape_we, tape_re;
    logic [TAW-1:0]   tape_waddr;
    logic [7:0]       tape_wdata, tape_q;
    logic             fifo_we, fifo_re;
    logic [7:0]       fifo_q;

    assign w_free  = !r_ov || i_ready;
    assign o_ready = (r_state == S_IDLE) && w_free;
    assign w_acc   = i_valid && o_ready;
    assign w_dec   = tli_pkg::decode_char(i_data);
    assign w_dm1   = r_depth - 1'b1;
    assign w_sym   = tli_pkg::t_sym'(prog_q);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_pc     = r_pc;
        n_depth  = r_depth;
        n_ptr    = r_ptr;
        n_clr    = r_clr;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_at     = r_at;
        w_emit   = 1'b0;
        w_obv    = 1'b0;
        w_obyte  = 8'd0;

        prog_we    = 1'b0;
        prog_re    = 1'b0;
        jt_we      = 1'b0;
        jt_re      = 1'b0;
        jt_waddr   = r_len[PAW-1:0];
        jt_wdata   = r_len[PAW-1:0];
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        tape_we    = 1'b0;
        tape_re    = 1'b0;
        tape_waddr = r_ptr;
        tape_wdata = 8'd0;
        fifo_we    = 1'b0;
        fifo_re    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == TAW'(TAPE_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    case (tli_pkg::t_op'(i_op))
                        tli_pkg::OP_LOAD_PROG: begin
                            w_emit = 1'b1;
                            if (w_dec.ok) begin
                                if (r_len == PCW'(PROG_LEN)) begin
                                    n_err = 1'b1;
                                end else begin
                                    prog_we = 1'b1;
                                    jt_we   = 1'b1;
                                    n_len   = r_len + 1'b1;
                                    n_at    = r_len[PAW-1:0];
                                    if (w_dec.sym == tli_pkg::SYM_OPEN) begin
                                        if (r_depth == SDW'(NEST_DEPTH)) begin
                                            n_err = 1'b1;
                                        end else begin
                                            stk_we  = 1'b1;
                                            n_depth = r_depth + 1'b1;
                                        end
                                    end else if (w_dec.sym == tli_pkg::SYM_CLOSE) begin
                                        if (r_depth == '0) begin
                                            n_err = 1'b1;
                                        end else begin
                                            // pop now, patch the table next
                                            stk_re  = 1'b1;
                                            n_depth = w_dm1;
                                            w_emit  = 1'b0;
                                            n_state = S_POP1;
                                        end
                                    end
                                end
                            end
                        end
                        tli_pkg::OP_LOAD_INPUT: begin
                            w_emit = 1'b1;
                            if (r_cnt != FCW'(INPUT_DEPTH)) begin
                                fifo_we = 1'b1;
                                n_cnt   = r_cnt + 1'b1;
                                n_tail  = (r_tail == FAW'(INPUT_DEPTH - 1)) ? '0
                                                                            : r_tail + 1'b1;
                            end
                        end
                        tli_pkg::OP_STEP: begin
                            if (r_err || r_depth != '0 || r_pc >= r_len) begin
                                w_emit = 1'b1;
                            end else begin
                                prog_re = 1'b1;
                                jt_re   = 1'b1;
                                tape_re = 1'b1;
                                fifo_re = 1'b1;
                                n_state = S_EXEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP1: begin
                jt_we    = 1'b1;
                jt_waddr = r_at;
                jt_wdata = stk_q;
                n_state  = S_POP2;
            end
            S_POP2: begin
                if (w_free) begin
                    jt_we    = 1'b1;
                    jt_waddr = stk_q;
                    jt_wdata = r_at;
                    w_emit   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EXEC: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    n_pc    = r_pc + 1'b1;
                    case (w_sym)
                        tli_pkg::SYM_LEFT: begin
                            n_ptr = (r_ptr == '0) ? TAW'(TAPE_CELLS - 1) : r_ptr - 1'b1;
                        end
                        tli_pkg::SYM_RIGHT: begin
                            n_ptr = (r_ptr == TAW'(TAPE_CELLS - 1)) ? '0 : r_ptr + 1'b1;
                        end
                        tli_pkg::SYM_INC: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_q + 8'd1;
                        end
                        tli_pkg::SYM_DEC: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_q - 8'd1;
                        end
                        tli_pkg::SYM_OUT: begin
                            w_obv   = 1'b1;
                            w_obyte = tape_q;
                        end
                        tli_pkg::SYM_IN: begin
                            tape_we = 1'b1;
                            if (r_cnt == '0) begin
                                tape_wdata = 8'hFF;
                            end else begin
                                tape_wdata = fifo_q;
                                n_cnt      = r_cnt - 1'b1;
                                n_head     = (r_head == FAW'(INPUT_DEPTH - 1)) ? '0
                                                                               : r_head + 1'b1;
                            end
                        end
                        tli_pkg::SYM_OPEN: begin
                            if (tape_q == 8'd0) begin
                                n_pc = PCW'(jt_q) + 1'b1;
                            end
                        end
                        tli_pkg::SYM_CLOSE: begin
                            if (tape_q != 8'd0) begin
                                n_pc = PCW'(jt_q) + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ov    = r_ov && !i_ready;
        n_obv   = r_obv;
        n_obyte = r_obyte;
        n_ohalt = r_ohalt;
        n_oerr  = r_oerr;
        if (w_emit) begin
            n_ov    = 1'b1;
            n_obv   = w_obv;
            n_obyte = w_obyte;
            n_ohalt = (n_pc >= n_len);
            n_oerr  = n_err || (n_depth != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_len   <= '0;
            r_pc    <= '0;
            r_depth <= '0;
            r_ptr   <= '0;
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pc    <= n_pc;
            r_depth <= n_depth;
            r_ptr   <= n_ptr;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_ov    <= n_ov;
        end
        r_at    <= n_at;
        r_obv   <= n_obv;
        r_obyte <= n_obyte;
        r_ohalt <= n_ohalt;
        r_oerr  <= n_oerr;
    end

    tli_ram #(.WIDTH(3), .DEPTH(PROG_LEN)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (r_len[PAW-1:0]),
        .i_wdata (w_dec.sym),
        .i_re    (prog_re),
        .i_raddr (r_pc[PAW-1:0]),
        .o_rdata (prog_q)
    );

    tli_ram #(.WIDTH(PAW), .DEPTH(PROG_LEN)) u_jump (
        .i_clk   (i_clk),
        .i_we    (jt_we),
        .i_waddr (jt_waddr),
        .i_wdata (jt_wdata),
        .i_re    (jt_re),
        .i_raddr (r_pc[PAW-1:0]),
        .o_rdata (jt_q)
    );

    tli_ram #(.WIDTH(PAW), .DEPTH(NEST_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[SAW-1:0]),
        .i_wdata (r_len[PAW-1:0]),
        .i_re    (stk_re),
        .i_raddr (w_dm1[SAW-1:0]),
        .o_rdata (stk_q)
    );

    tli_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_re    (tape_re),
        .i_raddr (r_ptr),
        .o_rdata (tape_q)
    );

    tli_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (r_tail),
        .i_wdata (i_data),
        .i_re    (fifo_re),
        .i_raddr (r_head),
        .o_rdata (fifo_q)
    );

    assign o_valid     = r_ov;
    assign o_out_valid = r_obv;
    assign o_out_byte  = r_obyte;
    assign o_halted    = r_ohalt;
    assign o_error     = r_oerr;

endmodule
